// ===== design/tea_pkg.sv =====
// tea_pkg: shared types and constants for the tea block cipher unit
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package tea_pkg;

    localparam int unsigned ROUNDS   = 32;
    localparam int unsigned N_CELLS  = 2 * ROUNDS;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [3:0]       key_t;

    localparam word_t DELTA = 32'h9e37_79b9;

    // running sum that decryption starts from, delta times the round count
    localparam logic [63:0] DEC_SUM_FULL = 64'(DELTA) * 64'(ROUNDS);
    localparam word_t       DEC_SUM_INIT = DEC_SUM_FULL[WORD_W-1:0];

    // encryption keeps the sum one delta ahead so each half step uses it as is
    localparam word_t       ENC_SUM_INIT = DELTA;

    typedef enum logic [0:0] {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 2'd3;

    typedef struct packed {
        op_t   op;
        word_t v0;
        word_t v1;
        word_t sum;
    } stage_t;

endpackage

// ===== design/tea_if.sv =====
// tea_in_if / tea_out_if: valid-ready channels for blocks in and results out
// depends on tea_pkg
`timescale 1ns / 1ps

interface tea_in_if;
    import tea_pkg::*;

    logic       valid;
    logic       ready;
    logic [0:0] opcode;
    word_t      word_first;
    word_t      word_second;

    modport source (output valid, output opcode, output word_first, output word_second,
                    input ready);
    modport sink   (input valid, input opcode, input word_first, input word_second,
                    output ready);
endinterface

interface tea_out_if;
    import tea_pkg::*;

    logic  valid;
    logic  ready;
    word_t out_first;
    word_t out_second;

    modport source (output valid, output out_first, output out_second, input ready);
    modport sink   (input valid, input out_first, input out_second, output ready);
endinterface

// ===== design/tea_block_cipher_unit.sv =====
// tea_block_cipher_unit: top level, key registers and a chain of half-round cells
// depends on tea_pkg, tea_if, tea_half_cell
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    opcode[0:0], word_first[31:0], word_second[31:0]
//   rsp      out  valid/ready    out_first[31:0], out_second[31:0]
//   cfg      in   cfg_we         cfg_index[1:0], cfg_data[31:0]
//
// one block accepted per cycle while the chain is not held; a result passes through
// every cell of the chain, one cell per half round, each cell one add-xor-add step
// the last cell is the output register; the whole chain holds while it is full and
// rsp.ready is low, bubbles are filled otherwise
// reset clears the valid bits and the keys, no clearing pass
`timescale 1ns / 1ps

module tea_block_cipher_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    tea_in_if.sink                       req,
    tea_out_if.source                    rsp,
    input  logic                         cfg_we,
    input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  tea_pkg::word_t               cfg_data
);
    import tea_pkg::*;

    key_t   key_reg;
    key_t   key_next;
    logic   advance;
    stage_t first_stage;

    logic   valid_chain [N_CELLS+1];
    stage_t data_chain  [N_CELLS+1];

    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY0: key_next[0] = cfg_data;
                CFG_KEY1: key_next[1] = cfg_data;
                CFG_KEY2: key_next[2] = cfg_data;
                CFG_KEY3: key_next[3] = cfg_data;
                default:  key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // global hold when the output word is stuck
    assign advance   = !valid_chain[N_CELLS] || rsp.ready;
    assign req.ready = advance;

    always_comb
    begin
        first_stage.op  = op_t'(req.opcode);
        first_stage.v0  = req.word_first;
        first_stage.v1  = req.word_second;
        first_stage.sum = (op_t'(req.opcode) == OP_DECRYPT) ? DEC_SUM_INIT : ENC_SUM_INIT;
    end

    assign valid_chain[0] = req.valid;
    assign data_chain[0]  = first_stage;

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        tea_half_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .odd_half  (1'(i % 2)),
            .key       (key_reg),
            .in_valid  (valid_chain[i]),
            .in_data   (data_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_data  (data_chain[i+1])
        );
    end

    assign rsp.valid      = valid_chain[N_CELLS];
    assign rsp.out_first  = data_chain[N_CELLS].v0;
    assign rsp.out_second = data_chain[N_CELLS].v1;

endmodule

// ===== design/tea_half_cell.sv =====
// tea_half_cell: one half round of tea, one register stage
// depends on tea_pkg
`timescale 1ns / 1ps

module tea_half_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            odd_half,
    input  tea_pkg::key_t   key,
    input  logic            in_valid,
    input  tea_pkg::stage_t in_data,
    output logic            out_valid,
    output tea_pkg::stage_t out_data
);
    import tea_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    logic  upd_first;
    logic  is_dec;
    word_t x;
    word_t y;
    word_t ka;
    word_t kb;
    word_t mix;
    word_t y_new;

    always_comb
    begin
        is_dec    = (in_data.op == OP_DECRYPT);
        // encrypt touches v0 first, decrypt touches v1 first
        upd_first = (is_dec == odd_half);
        x         = upd_first ? in_data.v1 : in_data.v0;
        y         = upd_first ? in_data.v0 : in_data.v1;
        ka        = upd_first ? key[0] : key[2];
        kb        = upd_first ? key[1] : key[3];
        mix       = ((x << 4) + ka) ^ (x + in_data.sum) ^ ((x >> 5) + kb);
        y_new     = is_dec ? (y - mix) : (y + mix);

        data_next = in_data;
        if (upd_first)
        begin
            data_next.v0 = y_new;
        end
        else
        begin
            data_next.v1 = y_new;
        end
        if (odd_half)
        begin
            data_next.sum = is_dec ? (in_data.sum - DELTA) : (in_data.sum + DELTA);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== verif/tea_block_cipher_unit_tb.sv =====
// tea_block_cipher_unit_tb: checks encrypt and decrypt blocks against a bit-exact tea model
// uses random idling on both channels and several key settings
// depends on tea_pkg, tea_if and tea_block_cipher_unit from the design folder
`timescale 1ns / 1ps

module tea_block_cipher_unit_tb;
    import tea_pkg::*;

    localparam word_t TEA_DELTA  = 32'h9e37_79b9;
    localparam int    PIPE_DEPTH = 2 * ROUNDS;

    typedef struct packed {
        word_t first;
        word_t second;
    } block_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    word_t                cfg_data;

    tea_in_if  req_if ();
    tea_out_if rsp_if ();

    tea_block_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    word_t  key_copy [4];
    block_t pending_blocks [$];
    int     err_count;
    bit     no_idle;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic word_t tea_mix(word_t x, word_t sum, word_t ka, word_t kb);
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

    function automatic block_t tea_transform(op_t op, word_t a, word_t b);
        word_t  v0;
        word_t  v1;
        word_t  sum;
        block_t res;
        v0 = a;
        v1 = b;
        if (op == OP_ENCRYPT)
        begin
            sum = '0;
            for (int r = 0; r < ROUNDS; r++)
            begin
                sum = sum + TEA_DELTA;
                v0  = v0 + tea_mix(v1, sum, key_copy[CFG_KEY0], key_copy[CFG_KEY1]);
                v1  = v1 + tea_mix(v0, sum, key_copy[CFG_KEY2], key_copy[CFG_KEY3]);
            end
        end
        else
        begin
            // delta times the round count, wrapped to 32 bits
            sum = word_t'(TEA_DELTA * ROUNDS);
            for (int r = 0; r < ROUNDS; r++)
            begin
                v1  = v1 - tea_mix(v0, sum, key_copy[CFG_KEY2], key_copy[CFG_KEY3]);
                v0  = v0 - tea_mix(v1, sum, key_copy[CFG_KEY0], key_copy[CFG_KEY1]);
                sum = sum - TEA_DELTA;
            end
        end
        res.first  = v0;
        res.second = v1;
        return res;
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 3))
            1: return $urandom_range(0, 1) ? '1 : '0;
            2: return word_t'(1) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // entered just after a falling edge; leaves valid high after the word is taken
    task automatic send_block(op_t op, word_t a, word_t b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.word_first  <= a;
        req_if.word_second <= b;
        do @(posedge clk); while (!req_if.ready);
        pending_blocks.push_back(tea_transform(op, a, b));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic drive_key(logic [CFG_IDX_W-1:0] idx, word_t val);
        cfg_we        <= 1'b1;
        cfg_index     <= idx;
        cfg_data      <= val;
        key_copy[idx] = val;
        @(negedge clk);
    endtask

    task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
        wait_drained();
        drive_key(CFG_KEY0, k0);
        drive_key(CFG_KEY1, k1);
        drive_key(CFG_KEY2, k2);
        drive_key(CFG_KEY3, k3);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // keys still at their reset value of zero
    task automatic test_reset_key();
        send_block(OP_ENCRYPT, '0, '0);
        send_block(OP_ENCRYPT, '1, '1);
        send_block(OP_DECRYPT, '0, '0);
        send_block(OP_DECRYPT, '1, '1);
    endtask

    task automatic test_key_extremes();
        load_key('1, '1, '1, '1);
        send_block(OP_ENCRYPT, '0, '1);
        send_block(OP_ENCRYPT, '1, '0);
        send_block(OP_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa);
        send_block(OP_DECRYPT, '1, '1);
        load_key('0, '1, '0, '1);
        send_block(OP_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
        send_block(OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
        load_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
        send_block(OP_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
        send_block(OP_DECRYPT, '0, '0);
    endtask

    // decrypting a ciphertext must give the plaintext back
    task automatic test_round_trip();
        word_t  a;
        word_t  b;
        block_t ct;
        for (int i = 0; i < 4; i++)
        begin
            a  = $urandom;
            b  = $urandom;
            ct = tea_transform(OP_ENCRYPT, a, b);
            send_block(OP_ENCRYPT, a, b);
            send_block(OP_DECRYPT, ct.first, ct.second);
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            load_key($urandom, $urandom, rand_word(), rand_word());
            no_idle = (phase == 3);
            for (int n = 0; n < 80; n++)
            begin
                send_block(op_t'($urandom_range(0, 1)), rand_word(), rand_word());
                // hold off until the pipeline is empty, then resume
                if (phase == 1 && n == 40)
                    wait_drained();
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random stalls, each word checked against the oldest prediction
    initial
    begin
        int     stall;
        block_t want;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            if (pending_blocks.size() == 0)
            begin
                $error("unexpected word out_first=%h out_second=%h",
                       rsp_if.out_first, rsp_if.out_second);
                err_count++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (rsp_if.out_first !== want.first)
                begin
                    $error("out_first expected %h actual %h", want.first, rsp_if.out_first);
                    err_count++;
                end
                if (rsp_if.out_second !== want.second)
                begin
                    $error("out_second expected %h actual %h", want.second, rsp_if.out_second);
                    err_count++;
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        #2_000_000;
        $display("tea_block_cipher_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.opcode      = '0;
        req_if.word_first  = '0;
        req_if.word_second = '0;
        no_idle            = 1'b0;
        err_count          = 0;
        foreach (key_copy[i])
            key_copy[i] = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_key();
        test_key_extremes();
        test_round_trip();
        test_random_traffic();

        wait_drained();
        repeat (PIPE_DEPTH + 8) @(negedge clk);
        if (err_count == 0 && pending_blocks.size() == 0)
            $display("tea_block_cipher_unit_tb OK");
        else
            $display("tea_block_cipher_unit_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tea_pkg.sv
design/tea_if.sv
design/tea_half_cell.sv
design/tea_block_cipher_unit.sv
verif/tea_block_cipher_unit_tb.sv
